>>> hdl/fdkd_pkg.sv
// Shared types, widths and codes of the fader deadband and key debounce core.
`timescale 1ns / 1ps
`default_nettype none

package fdkd_pkg;

  localparam int LANES      = 5;
  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 48;
  localparam int LOCKOUT_W  = 24;
  localparam int KEY_NUM_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0]   DEADBAND_RESET = 8'd2;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET  = 24'd50000;

  localparam logic CMD_POLL   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADER_DEADBAND  = 3'd0,
    REG_KEY_LOCKOUT_US  = 3'd1,
    REG_FADER_REPORT_EN = 3'd2,
    REG_KEY_REPORT_EN   = 3'd3,
    REG_IGNORED_KEYS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_FADER    = 2'd0,
    KIND_KEY_HOST = 2'd1,
    KIND_KEY_HID  = 2'd2
  } report_kind_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]   deadband;
    logic [LOCKOUT_W-1:0] lockout;
    logic                 fader_en;
    logic                 key_en;
    logic [LANES-1:0]     ignored;
  } cfg_t;

  typedef struct packed {
    logic                              command;
    logic [LANES-1:0][SAMPLE_W-1:0]    sample;
    logic [LANES-1:0]                  valid;
    logic [LANES-1:0]                  levels;
    logic                              link;
    logic                              busy;
    logic [TIME_W-1:0]                 now;
  } item_t;

  typedef struct packed {
    logic                            fader;
    logic [LANES-1:0][LEVEL_W-1:0]   levels;
    logic [LANES-1:0]                keys;
    logic                            link;
  } bundle_t;

endpackage

`default_nettype wire

>>> hdl/fdkd_ifs.sv
// Handshake channel interfaces for poll words, report words and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface fdkd_poll_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [9:0]  fader_a;
  logic [9:0]  fader_b;
  logic [9:0]  fader_c;
  logic [9:0]  fader_d;
  logic [9:0]  fader_e;
  logic [4:0]  sample_valid;
  logic [4:0]  key_levels;
  logic        host_link_up;
  logic        update_busy;
  logic [47:0] now_us;

  modport source (output valid, command, fader_a, fader_b, fader_c, fader_d, fader_e,
                  sample_valid, key_levels, host_link_up, update_busy, now_us,
                  input ready);
  modport sink (input valid, command, fader_a, fader_b, fader_c, fader_d, fader_e,
                sample_valid, key_levels, host_link_up, update_busy, now_us,
                output ready);
endinterface

interface fdkd_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] report_kind;
  logic [7:0] level_a;
  logic [7:0] level_b;
  logic [7:0] level_c;
  logic [7:0] level_d;
  logic [7:0] level_e;
  logic [2:0] key_number;
  logic       final_of_run;

  modport source (output valid, report_kind, level_a, level_b, level_c, level_d, level_e,
                  key_number, final_of_run, input ready);
  modport sink (input valid, report_kind, level_a, level_b, level_c, level_d, level_e,
                key_number, final_of_run, output ready);
endinterface

interface fdkd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/fader_deadband_and_key_debounce_core.sv
// Top level of the fader deadband reporter and key press lockout core.
//
//   Channel  Dir  Handshake      Word
//   poll     in   valid/ready    command, five fader samples, masks, flags, timestamp
//   report   out  valid/ready    report kind, five 8-bit levels, key number, last flag
//   cfg      in   valid/ready    register index and write data (ready is always high)
//
// A poll word is captured in an input register and is evaluated in the cycle it
// leaves that register for the result register; the evaluation also updates the
// fader baselines and the key state. The result register then hands out one report
// word per cycle while not stalled, so a word that gives n reports holds the result
// side until all are taken and a word that gives at most one report passes at one
// word per cycle. The input register takes the next word while reports are still
// waiting, and a stall on the report side back-pressures the poll side only once the
// input register is full. Reset is synchronous and resets the configuration, the
// baselines, the key state and both registers at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fader_deadband_and_key_debounce_core
  import fdkd_pkg::*;
#(
  parameter int FADER_COUNT = 5,
  parameter int KEY_COUNT   = 5
) (
  input  wire logic      clk,
  input  wire logic      rst,
  fdkd_poll_if.sink      poll,
  fdkd_report_if.source  report,
  fdkd_cfg_if.sink       cfg
);

  cfg_t    regs;
  item_t   item_d;
  item_t   item_q;
  bundle_t bundle;
  logic    full;
  logic    advance;
  logic    seq_free;
  logic    has_result;

  // The held word moves on once the result register can take its reports.
  assign advance    = full && seq_free;
  assign poll.ready = !full || advance;

  always_comb begin
    item_d.command   = poll.command;
    item_d.sample[0] = poll.fader_a;
    item_d.sample[1] = poll.fader_b;
    item_d.sample[2] = poll.fader_c;
    item_d.sample[3] = poll.fader_d;
    item_d.sample[4] = poll.fader_e;
    item_d.valid     = poll.sample_valid;
    item_d.levels    = poll.key_levels;
    item_d.link      = poll.host_link_up;
    item_d.busy      = poll.update_busy;
    item_d.now       = poll.now_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (poll.valid && poll.ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
    if (poll.valid && poll.ready) begin
      item_q <= item_d;
    end
  end

  fdkd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fdkd_eval #(
    .FADER_COUNT (FADER_COUNT),
    .KEY_COUNT   (KEY_COUNT)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .item       (item_q),
    .regs       (regs),
    .take       (advance),
    .bundle     (bundle),
    .has_result (has_result)
  );

  // A word with no reports is simply dropped after its state update.
  fdkd_report_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_result),
    .bundle (bundle),
    .free   (seq_free),
    .report (report)
  );

endmodule

`default_nettype wire

>>> hdl/fdkd_cfg_regs.sv
// Configuration register file written through the register write channel.
`timescale 1ns / 1ps
`default_nettype none

module fdkd_cfg_regs
  import fdkd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fdkd_cfg_if.sink  cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.deadband <= DEADBAND_RESET;
      regs.lockout  <= LOCKOUT_RESET;
      regs.fader_en <= 1'b1;
      regs.key_en   <= 1'b1;
      regs.ignored  <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_FADER_DEADBAND:  regs.deadband <= cfg.data[LEVEL_W-1:0];
        REG_KEY_LOCKOUT_US:  regs.lockout  <= cfg.data[LOCKOUT_W-1:0];
        REG_FADER_REPORT_EN: regs.fader_en <= cfg.data[0];
        REG_KEY_REPORT_EN:   regs.key_en   <= cfg.data[0];
        REG_IGNORED_KEYS:    regs.ignored  <= cfg.data[LANES-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/fdkd_eval.sv
// Per-word evaluation: fader deadband test, key edge and lockout test, and the state they update.
`timescale 1ns / 1ps
`default_nettype none

module fdkd_eval
  import fdkd_pkg::*;
#(
  parameter int FADER_COUNT = 5,
  parameter int KEY_COUNT   = 5
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire item_t  item,
  input  wire cfg_t   regs,
  input  wire logic   take,
  output bundle_t     bundle,
  output logic        has_result
);

  localparam int FadersUsed = (FADER_COUNT < LANES) ? FADER_COUNT : LANES;
  localparam int KeysUsed   = (KEY_COUNT < LANES) ? KEY_COUNT : LANES;

  logic [LEVEL_W-1:0] baseline [LANES];
  logic [LANES-1:0]   prev_level;
  logic [TIME_W-1:0]  accept_time [LANES];

  logic [LEVEL_W-1:0] baseline_next [LANES];
  logic [LANES-1:0]   level_now;
  logic [LANES-1:0]   emit;
  logic [LEVEL_W-1:0] cur [LANES];
  logic [LEVEL_W-1:0] diff [LANES];
  logic [TIME_W-1:0]  since [LANES];
  logic               all_valid;
  logic               over;
  logic               do_poll;
  logic               resync;
  logic               fader_report;

  always_comb begin
    resync    = (item.command == CMD_RESYNC);
    do_poll   = (item.command == CMD_POLL) && !item.busy;
    all_valid = (FADER_COUNT <= LANES);
    over      = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      cur[j]  = item.sample[j][SAMPLE_W-1:SAMPLE_W-LEVEL_W];
      diff[j] = (cur[j] >= baseline[j]) ? cur[j] - baseline[j] : baseline[j] - cur[j];
      if (j < FadersUsed) begin
        if (!item.valid[j]) all_valid = 1'b0;
        if (diff[j] >= regs.deadband) over = 1'b1;
      end
    end

    if (resync) begin
      fader_report = regs.fader_en && item.link;
    end else begin
      fader_report = do_poll && item.link && regs.fader_en && all_valid && over;
    end

    for (int j = 0; j < LANES; j++) begin
      baseline_next[j] = baseline[j];
      if (j < FadersUsed) begin
        if (resync && item.valid[j]) baseline_next[j] = cur[j];
        if (!resync && fader_report) baseline_next[j] = cur[j];
      end
      // Unused or ignored keys always read as released.
      level_now[j] = (j < KeysUsed && !regs.ignored[j]) ? item.levels[j] : 1'b1;
      since[j]     = item.now - accept_time[j];
      emit[j]      = do_poll && regs.key_en && !level_now[j] && prev_level[j] &&
                     (item.now >= accept_time[j]) &&
                     (since[j] >= {{(TIME_W-LOCKOUT_W){1'b0}}, regs.lockout});
    end

    bundle.fader = fader_report;
    bundle.keys  = emit;
    bundle.link  = item.link;
    for (int j = 0; j < LANES; j++) begin
      bundle.levels[j] = (j < FadersUsed) ? baseline_next[j] : '0;
    end
    has_result = fader_report || (|emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= '1;
      for (int j = 0; j < LANES; j++) begin
        baseline[j]    <= '0;
        accept_time[j] <= '0;
      end
    end else if (take) begin
      for (int j = 0; j < LANES; j++) begin
        baseline[j] <= baseline_next[j];
        if (emit[j]) accept_time[j] <= item.now;
      end
      if (do_poll) prev_level <= level_now;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fdkd_report_seq.sv
// Result register that hands out the reports of one evaluated word, one per cycle while the report side is ready.
`timescale 1ns / 1ps
`default_nettype none

module fdkd_report_seq
  import fdkd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire bundle_t  bundle,
  output logic          free,
  fdkd_report_if.source report
);

  logic                          pend_fader;
  logic [LANES-1:0]              pend_keys;
  logic [LANES-1:0][LEVEL_W-1:0] levels;
  logic                          link;

  logic [KEY_NUM_W-1:0] first_key;
  logic [LANES-1:0]     rest_keys;
  logic                 busy;
  logic                 last;
  logic                 taken;

  always_comb begin
    first_key = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (pend_keys[j]) first_key = KEY_NUM_W'(j);
    end
    rest_keys = pend_keys & (pend_keys - LANES'(1));
    busy      = pend_fader || (|pend_keys);
    last      = pend_fader ? (pend_keys == '0) : (rest_keys == '0);
    taken     = report.valid && report.ready;
    free      = !busy || (taken && last);
  end

  assign report.valid        = busy;
  assign report.report_kind  = pend_fader ? KIND_FADER : (link ? KIND_KEY_HOST : KIND_KEY_HID);
  assign report.level_a      = pend_fader ? levels[0] : '0;
  assign report.level_b      = pend_fader ? levels[1] : '0;
  assign report.level_c      = pend_fader ? levels[2] : '0;
  assign report.level_d      = pend_fader ? levels[3] : '0;
  assign report.level_e      = pend_fader ? levels[4] : '0;
  assign report.key_number   = pend_fader ? '0 : first_key;
  assign report.final_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_fader <= 1'b0;
      pend_keys  <= '0;
    end else if (load) begin
      pend_fader <= bundle.fader;
      pend_keys  <= bundle.keys;
      levels     <= bundle.levels;
      link       <= bundle.link;
    end else if (taken) begin
      if (pend_fader) begin
        pend_fader <= 1'b0;
      end else begin
        pend_keys <= rest_keys;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/fdkd_checker.sv
// Port-level checks of the core, attached to the top level by a bind.
`timescale 1ns / 1ps
`default_nettype none

module fdkd_checker
  import fdkd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rep_valid,
  input wire logic       rep_ready,
  input wire logic [1:0] rep_kind,
  input wire logic [7:0] rep_level_a,
  input wire logic [7:0] rep_level_e,
  input wire logic [2:0] rep_key,
  input wire logic       rep_final
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rep_valid && !rep_ready |=> rep_valid && $stable(rep_kind) && $stable(rep_key) &&
      $stable(rep_level_a) && $stable(rep_final))
    else $error("report word changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    rep_valid && rep_ready && !rep_final |=> rep_valid)
    else $error("report run broke off before its last word");

  a_fader_no_key: assert property (@(posedge clk) disable iff (rst)
    rep_valid && rep_kind == KIND_FADER |-> rep_key == 3'd0)
    else $error("fader report carries a key number");

  a_key_no_levels: assert property (@(posedge clk) disable iff (rst)
    rep_valid && (rep_kind == KIND_KEY_HOST || rep_kind == KIND_KEY_HID) |->
      rep_level_a == 8'd0 && rep_level_e == 8'd0 && rep_key < 3'd5)
    else $error("key event carries fader levels or a bad key number");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rep_valid |-> rep_kind != 2'd3)
    else $error("illegal report kind");

endmodule

bind fader_deadband_and_key_debounce_core fdkd_checker u_fdkd_checker (
  .clk         (clk),
  .rst         (rst),
  .rep_valid   (report.valid),
  .rep_ready   (report.ready),
  .rep_kind    (report.report_kind),
  .rep_level_a (report.level_a),
  .rep_level_e (report.level_e),
  .rep_key     (report.key_number),
  .rep_final   (report.final_of_run)
);

`default_nettype wire
